[hw/rtl/bc6m10_pkg.sv]
package bc6m10_pkg;

	localparam int NUM_CHAN = 3;
	localparam int EP_BITS = 10;
	localparam int HALF_BITS = 15;
	localparam int FULL_BITS = 16;
	localparam int W_BITS = 7;

	localparam logic [4:0] MODE_TEN_CODE = 5'd3;
	localparam logic [6:0] WEIGHT_ONE = 7'd64;
	localparam logic [3:0] LAST_TEXEL_NUM = 4'd15;

	typedef logic [FULL_BITS-1:0] chan_t;

	// one texel on its way through the blend pipeline
	typedef struct packed {
		logic [3:0] texel_number;
		logic last_texel;
		logic mode_ok;
		logic [W_BITS-1:0] weight;
		chan_t [NUM_CHAN-1:0] ep0;
		chan_t [NUM_CHAN-1:0] ep1;
	} texel_job_t;

	function automatic logic [W_BITS-1:0] weight_of(input logic [3:0] idx);
		logic [W_BITS-1:0] w;
		case (idx)
			4'd0: w = 7'd0;
			4'd1: w = 7'd4;
			4'd2: w = 7'd9;
			4'd3: w = 7'd13;
			4'd4: w = 7'd17;
			4'd5: w = 7'd21;
			4'd6: w = 7'd26;
			4'd7: w = 7'd30;
			4'd8: w = 7'd34;
			4'd9: w = 7'd38;
			4'd10: w = 7'd43;
			4'd11: w = 7'd47;
			4'd12: w = 7'd51;
			4'd13: w = 7'd55;
			4'd14: w = 7'd60;
			4'd15: w = 7'd64;
			default: w = 7'd0;
		endcase
		return w;
	endfunction

	// exact ends at zero and full scale, midpoint rounding elsewhere
	function automatic chan_t expand_ep(input logic [EP_BITS-1:0] q);
		chan_t e;
		if (q == '0) begin
			e = '0;
		end else if (q == '1) begin
			e = '1;
		end else begin
			e = {q, 6'd32};
		end
		return e;
	endfunction

endpackage

[hw/rtl/bc6m10_ifs.sv]
interface bc6m10_blk_if;
	logic valid;
	logic ready;
	logic [63:0] block_low;
	logic [63:0] block_high;

	modport source(output valid, output block_low, output block_high, input ready);
	modport sink(input valid, input block_low, input block_high, output ready);
endinterface

interface bc6m10_texel_if;
	logic valid;
	logic ready;
	logic [3:0] texel_number;
	logic [14:0] red_half;
	logic [14:0] green_half;
	logic [14:0] blue_half;
	logic mode_ok;
	logic last_texel;

	modport source(output valid, output texel_number, output red_half, output green_half,
		output blue_half, output mode_ok, output last_texel, input ready);
	modport sink(input valid, input texel_number, input red_half, input green_half,
		input blue_half, input mode_ok, input last_texel, output ready);
endinterface

[hw/rtl/bc6m10_unpack.sv]
module bc6m10_unpack
	import bc6m10_pkg::*;
(
	input logic clk,
	input logic arst_n,
	bc6m10_blk_if.sink blk,
	input logic advance,
	output logic job_v_s1,
	output texel_job_t job_s1
);

	logic hold_v_q;
	logic [3:0] cnt_q;
	logic ok_q;
	chan_t [NUM_CHAN-1:0] ep0_q;
	chan_t [NUM_CHAN-1:0] ep1_q;
	logic [63:0] idx_q;
	logic [127:0] word;
	logic load;
	logic emit;

	assign word = {blk.block_high, blk.block_low};
	assign blk.ready = !hold_v_q || ((cnt_q == LAST_TEXEL_NUM) && advance);
	assign load = blk.valid && blk.ready;
	assign emit = hold_v_q && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			cnt_q <= '0;
			job_v_s1 <= 1'b0;
		end else begin
			if (advance) begin
				job_v_s1 <= hold_v_q;
			end
			if (load) begin
				hold_v_q <= 1'b1;
				cnt_q <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == LAST_TEXEL_NUM) begin
					hold_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			job_s1.texel_number <= cnt_q;
			job_s1.last_texel <= (cnt_q == LAST_TEXEL_NUM);
			job_s1.mode_ok <= ok_q;
			job_s1.weight <= weight_of(idx_q[3:0]);
			job_s1.ep0 <= ep0_q;
			job_s1.ep1 <= ep1_q;
		end
		if (load) begin
			ok_q <= (blk.block_low[4:0] == MODE_TEN_CODE);
			// texel 0 keeps only three index bits
			idx_q <= {blk.block_high[63:4], 1'b0, blk.block_high[3:1]};
			for (int c = 0; c < NUM_CHAN; c++) begin
				// zero endpoints for other modes so colors blend to zero
				if (blk.block_low[4:0] == MODE_TEN_CODE) begin
					ep0_q[c] <= expand_ep(word[5 + c*EP_BITS +: EP_BITS]);
					ep1_q[c] <= expand_ep(word[5 + (NUM_CHAN + c)*EP_BITS +: EP_BITS]);
				end else begin
					ep0_q[c] <= '0;
					ep1_q[c] <= '0;
				end
			end
		end else if (emit) begin
			idx_q <= idx_q >> 4;
		end
	end

endmodule

[hw/rtl/bc6m10_blend.sv]
module bc6m10_blend
	import bc6m10_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic job_v_s1,
	input texel_job_t job_s1,
	output logic v_s4,
	output logic [3:0] texel_number_s4,
	output logic last_texel_s4,
	output logic mode_ok_s4,
	output logic [NUM_CHAN-1:0][HALF_BITS-1:0] half_s4
);

	localparam int PROD_BITS = FULL_BITS + W_BITS;

	logic v_s2, v_s3;
	logic [3:0] num_s2, num_s3;
	logic last_s2, last_s3;
	logic ok_s2, ok_s3;
	logic [NUM_CHAN-1:0][PROD_BITS-1:0] p0_s2, p1_s2;
	chan_t [NUM_CHAN-1:0] mix_s3;
	logic [W_BITS-1:0] inv_w;
	logic [NUM_CHAN-1:0][PROD_BITS:0] sum;
	logic [NUM_CHAN-1:0][HALF_BITS+5:0] scaled;

	assign inv_w = WEIGHT_ONE - job_s1.weight;

	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			sum[c] = (PROD_BITS+1)'(p0_s2[c]) + (PROD_BITS+1)'(p1_s2[c])
				+ (PROD_BITS+1)'(32);
			// times 31 as shift and subtract
			scaled[c] = {mix_s3[c], 5'd0} - (HALF_BITS+6)'(mix_s3[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s2 <= job_v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			num_s2 <= job_s1.texel_number;
			last_s2 <= job_s1.last_texel;
			ok_s2 <= job_s1.mode_ok;
			num_s3 <= num_s2;
			last_s3 <= last_s2;
			ok_s3 <= ok_s2;
			texel_number_s4 <= num_s3;
			last_texel_s4 <= last_s3;
			mode_ok_s4 <= ok_s3;
			for (int c = 0; c < NUM_CHAN; c++) begin
				p0_s2[c] <= PROD_BITS'(job_s1.ep0[c]) * PROD_BITS'(inv_w);
				p1_s2[c] <= PROD_BITS'(job_s1.ep1[c]) * PROD_BITS'(job_s1.weight);
				// the rounded mix never exceeds full scale, so sixteen bits hold it
				mix_s3[c] <= sum[c][FULL_BITS+5:6];
				half_s4[c] <= scaled[c][HALF_BITS+5:6];
			end
		end
	end

endmodule

[hw/rtl/bc6h_mode10_block_decoder.sv]
// The first texel of a block passes from the holder through s1, s2, s3 and s4 before it is offered.
// Throughput: one texel per cycle while the texel side does not stall, set by the one
// blend pipeline that every texel passes through in turn.
// Reset: arst_n clears the block holder, texel counter and all stage valid bits at once;
// data registers are not reset.
module bc6h_mode10_block_decoder
	import bc6m10_pkg::*;
(
	input logic clk,
	input logic arst_n,
	bc6m10_blk_if.sink blk,
	bc6m10_texel_if.source texel
);

	// Structure:
	//   unpack  - holds one block, expands its six endpoints when the beat is taken and
	//             walks a counter over the sixteen indices, one texel job per cycle unless stalled (s1).
	//   blend   - s2 forms both weighted products per channel, s3 adds and rounds to
	//             the 16-bit mix, s4 scales by 31/64 into the output register.
	// Every stage moves together on advance; a stall on the texel side freezes all of
	// them, bubbles included. The next block may be taken in the cycle the sixteenth
	// texel leaves the holder, so blocks follow with no gap.

	logic advance;
	logic job_v_s1;
	texel_job_t job_s1;
	logic v_s4;
	logic [3:0] texel_number_s4;
	logic last_texel_s4;
	logic mode_ok_s4;
	logic [NUM_CHAN-1:0][HALF_BITS-1:0] half_s4;

	// advance whenever the output register is empty or its beat is being taken
	assign advance = !v_s4 || texel.ready;

	bc6m10_unpack u_unpack (
		.clk(clk),
		.arst_n(arst_n),
		.blk(blk),
		.advance(advance),
		.job_v_s1(job_v_s1),
		.job_s1(job_s1)
	);

	bc6m10_blend u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.job_v_s1(job_v_s1),
		.job_s1(job_s1),
		.v_s4(v_s4),
		.texel_number_s4(texel_number_s4),
		.last_texel_s4(last_texel_s4),
		.mode_ok_s4(mode_ok_s4),
		.half_s4(half_s4)
	);

	// drive the texel beat straight from the last stage
	assign texel.valid = v_s4;
	assign texel.texel_number = texel_number_s4;
	assign texel.red_half = half_s4[0];
	assign texel.green_half = half_s4[1];
	assign texel.blue_half = half_s4[2];
	assign texel.mode_ok = mode_ok_s4;
	assign texel.last_texel = last_texel_s4;

endmodule
